// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every edge
`define NBVS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// ante at this edge implies cons at the same edge
`define NBVS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// ante at this edge implies cons at the next edge
`define NBVS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/nbvs_pkg.sv =====
// ----------------------------------------------------------------------------
// nbvs_pkg
// Shared types and constants of the nearest building vertex search.
// ----------------------------------------------------------------------------
package nbvs_pkg;

  localparam int BLD_W   = 3;
  localparam int VTX_W   = 5;
  localparam int LAT_W   = 28;
  localparam int LON_W   = 29;
  localparam int WGT_W   = 10;
  localparam int DIST_W  = 64;
  localparam int COORD_W = LAT_W + LON_W;
  localparam int CFG_IDX_W = 2;

  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;

  localparam logic [WGT_W-1:0]  LAT_WEIGHT_RST = WGT_W'(91);
  localparam logic [WGT_W-1:0]  LON_WEIGHT_RST = WGT_W'(111);
  localparam logic [DIST_W-1:0] LIMIT_SQ_RST   = 64'd1020304050000000000;

  localparam logic [CFG_IDX_W-1:0] CFG_LAT_WEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LON_WEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_SQ   = 2'd2;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic             en;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_DIFF,
    ST_MLAT,
    ST_SQLAT,
    ST_MLON,
    ST_SQLON,
    ST_ACC,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/core/nbvs_ram.sv =====
// ----------------------------------------------------------------------------
// nbvs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nbvs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/nbvs_mul.sv =====
// ----------------------------------------------------------------------------
// nbvs_mul
// Shared 32x32 unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
module nbvs_mul (
  input  logic                      clk,
  input  nbvs_pkg::mul_req_t        req,
  output logic [nbvs_pkg::PROD_W-1:0] prod
);

  import nbvs_pkg::*;

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod <= PROD_W'(req.a) * PROD_W'(req.b);
    end
  end

endmodule

// ===== rtl/core/nearest_building_vertex_search.sv =====
// ----------------------------------------------------------------------------
// nearest_building_vertex_search
// Vertex table with a sequenced nearest-vertex walk on one shared multiplier.
// ----------------------------------------------------------------------------
//  channel | dir | ports                           | beat
//  in      | in  | in_tvalid/tready/tdata/tuser    | vertex write or query point
//  out     | out | out_tvalid/tready/tdata/tuser   | answer, one per query
//  cfg     | in  | cfg_valid/ready/index/data      | register write
//
// A vertex write is stored when its beat is accepted. A query walks all D
// table entries, of which V are valid: each valid entry makes four passes
// through the shared multiplier plus a read, a subtract and an accumulate step.
// Reset clears all valid bits at once, no clearing pass.
// in_tready is low while a query walks; a finished answer waits in the output
// register, and the next item is taken as soon as it is loaded.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nearest_building_vertex_search #(
  parameter int NUM_BUILDINGS      = 8,
  parameter int VERTS_PER_BUILDING = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [71:0]                       in_tdata,   // building, vertex, latitude, longitude
  input  logic                              in_tuser,   // command
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [7:0]                        out_tdata,  // nearest_building
  output logic                              out_tuser,  // found
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [nbvs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nbvs_pkg::DIST_W-1:0]       cfg_data
);

  import nbvs_pkg::*;

  localparam int BLD_SPAN = 1 << BLD_W;
  localparam int VTX_SPAN = 1 << VTX_W;
  localparam int NBE = (NUM_BUILDINGS < BLD_SPAN) ? NUM_BUILDINGS : BLD_SPAN;
  localparam int VPE = (VERTS_PER_BUILDING < VTX_SPAN) ? VERTS_PER_BUILDING : VTX_SPAN;
  localparam int DEPTH = NBE * VPE;
  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BCW = (NBE > 1) ? $clog2(NBE) : 1;
  localparam int VCW = (VPE > 1) ? $clog2(VPE) : 1;

  // input beat fields
  logic [BLD_W-1:0] in_bld;
  logic [VTX_W-1:0] in_vtx;
  logic [LAT_W-1:0] in_lat;
  logic [LON_W-1:0] in_lon;
  assign in_bld = in_tdata[2:0];
  assign in_vtx = in_tdata[7:3];
  assign in_lat = in_tdata[35:8];
  assign in_lon = in_tdata[64:36];

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  // config
  logic [WGT_W-1:0]  lat_w_r;
  logic [WGT_W-1:0]  lon_w_r;
  logic [DIST_W-1:0] limit_r;
  assign cfg_ready = 1'b1;

  // control state
  state_t           state_r, state_nxt;
  logic [DEPTH-1:0] valid_r;
  logic [AW-1:0]    addr_r;
  logic [BCW-1:0]   bcnt_r;
  logic [VCW-1:0]   vcnt_r;
  logic             found_r;
  logic [BLD_W-1:0] held_r;
  logic             out_valid_r;

  // payload
  logic [LAT_W-1:0]  qlat_r;
  logic [LON_W-1:0]  qlon_r;
  logic [LAT_W-1:0]  dlat_r;
  logic [LON_W-1:0]  dlon_r;
  logic              sat_lat_r;
  logic              sat_lon_r;
  logic [DIST_W-1:0] lat_sq_r;
  logic [DIST_W-1:0] best_r;
  logic [BLD_W-1:0]  ans_r;
  logic [BLD_W-1:0]  out_bld_r;
  logic              out_found_r;

  // write path
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  assign wr_en   = in_acc && (in_tuser == CMD_WRITE)
                   && (int'(in_bld) < NBE) && (int'(in_vtx) < VPE);
  assign wr_addr = AW'(int'(in_bld) * VPE + int'(in_vtx));

  // table
  logic               ram_re;
  logic [COORD_W-1:0] ram_rdata;

  nbvs_ram #(
    .WIDTH (COORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata ({in_lon, in_lat}),
    .re    (ram_re),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  // shared multiplier
  mul_req_t          mul_req;
  logic [PROD_W-1:0] prod;

  nbvs_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  logic cur_valid;
  logic last_entry;
  logic step;
  logic load_out;
  assign cur_valid  = valid_r[addr_r];
  assign last_entry = (addr_r == AW'(DEPTH - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_tuser == CMD_QUERY)) state_nxt = ST_READ;
      end
      ST_READ: begin
        if (cur_valid)       state_nxt = ST_DIFF;
        else if (last_entry) state_nxt = ST_DONE;
      end
      ST_DIFF:  state_nxt = ST_MLAT;
      ST_MLAT:  state_nxt = ST_SQLAT;
      ST_SQLAT: state_nxt = ST_MLON;
      ST_MLON:  state_nxt = ST_SQLON;
      ST_SQLON: state_nxt = ST_ACC;
      ST_ACC:   state_nxt = last_entry ? ST_DONE : ST_READ;
      ST_DONE: begin
        if (load_out) state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    ram_re    = 1'b0;
    step      = 1'b0;
    load_out  = 1'b0;
    mul_req   = '0;
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_READ: begin
        ram_re = cur_valid;
        step   = !cur_valid;
      end
      ST_MLAT: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_W'(dlat_r);
        mul_req.b  = MUL_W'(lat_w_r);
      end
      ST_SQLAT, ST_SQLON: begin
        mul_req.en = 1'b1;
        mul_req.a  = prod[MUL_W-1:0];
        mul_req.b  = prod[MUL_W-1:0];
      end
      ST_MLON: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_W'(dlon_r);
        mul_req.b  = MUL_W'(lon_w_r);
      end
      ST_ACC:  step     = 1'b1;
      ST_DONE: load_out = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  // distance arithmetic
  logic signed [LAT_W:0]  dlat_s;
  logic signed [LON_W:0]  dlon_s;
  logic [LAT_W:0]         dlat_abs;
  logic [LON_W:0]         dlon_abs;
  logic [DIST_W-1:0]      lon_sq;
  logic [DIST_W:0]        sum;
  logic [DIST_W-1:0]      dsq;
  logic [BLD_W-1:0]       final_bld;

  always_comb begin
    dlat_s   = $signed({qlat_r[LAT_W-1], qlat_r})
             - $signed({ram_rdata[LAT_W-1], ram_rdata[LAT_W-1:0]});
    dlon_s   = $signed({qlon_r[LON_W-1], qlon_r})
             - $signed({ram_rdata[COORD_W-1], ram_rdata[COORD_W-1:LAT_W]});
    dlat_abs = dlat_s[LAT_W] ? (LAT_W+1)'(-dlat_s) : dlat_s;
    dlon_abs = dlon_s[LON_W] ? (LON_W+1)'(-dlon_s) : dlon_s;
    lon_sq   = sat_lon_r ? '1 : prod;
    sum      = {1'b0, lat_sq_r} + {1'b0, lon_sq};
    dsq      = sum[DIST_W] ? '1 : sum[DIST_W-1:0];
    final_bld = found_r ? ans_r : held_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      addr_r      <= '0;
      bcnt_r      <= '0;
      vcnt_r      <= '0;
      found_r     <= 1'b0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
      lat_w_r     <= LAT_WEIGHT_RST;
      lon_w_r     <= LON_WEIGHT_RST;
      limit_r     <= LIMIT_SQ_RST;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LAT_WEIGHT: lat_w_r <= cfg_data[WGT_W-1:0];
          CFG_LON_WEIGHT: lon_w_r <= cfg_data[WGT_W-1:0];
          CFG_LIMIT_SQ:   limit_r <= cfg_data;
          default: ;
        endcase
      end
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (state_r == ST_IDLE) begin
        addr_r  <= '0;
        bcnt_r  <= '0;
        vcnt_r  <= '0;
        found_r <= 1'b0;
      end else if (step) begin
        addr_r <= addr_r + AW'(1);
        if (vcnt_r == VCW'(VPE - 1)) begin
          vcnt_r <= '0;
          bcnt_r <= bcnt_r + BCW'(1);
        end else begin
          vcnt_r <= vcnt_r + VCW'(1);
        end
      end
      if ((state_r == ST_ACC) && (dsq < best_r)) begin
        found_r <= 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
        held_r      <= final_bld;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      qlat_r <= in_lat;
      qlon_r <= in_lon;
      best_r <= limit_r;
    end
    if (state_r == ST_DIFF) begin
      dlat_r <= dlat_abs[LAT_W-1:0];
      dlon_r <= dlon_abs[LON_W-1:0];
    end
    if (state_r == ST_SQLAT) begin
      sat_lat_r <= |prod[PROD_W-1:MUL_W];
    end
    if (state_r == ST_MLON) begin
      lat_sq_r <= sat_lat_r ? '1 : prod;
    end
    if (state_r == ST_SQLON) begin
      sat_lon_r <= |prod[PROD_W-1:MUL_W];
    end
    if ((state_r == ST_ACC) && (dsq < best_r)) begin
      best_r <= dsq;
      ans_r  <= BLD_W'(bcnt_r);
    end
    if (load_out) begin
      out_bld_r   <= final_bld;
      out_found_r <= found_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = 8'(out_bld_r);
  assign out_tuser  = out_found_r;

  `NBVS_ASSERT_IMPL(a_out_from_done, $rose(out_tvalid), $past(state_r == ST_DONE), "answer without finished walk")
  `NBVS_ASSERT_NEXT(a_held_tracks, load_out && found_r, held_r == out_bld_r, "held building not updated")
  `NBVS_ASSERT_IMPL(a_best_monotone, (state_r != ST_IDLE) && $past(state_r != ST_IDLE), best_r <= $past(best_r), "best distance grew during walk")
  `NBVS_ASSERT_IMPL(a_found_in_limit, found_r && (state_r != ST_IDLE), best_r < limit_r, "found without beating limit")
  `NBVS_ASSERT(a_busy_no_accept, !(in_acc && (state_r != ST_IDLE)), "input beat taken during walk")

endmodule
